[sv/assert_macros.svh]
// Assertion macros for the RTL of the K-Line frame receiver.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge while the block is out of reset.
`define KLFRC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checked at every rising clock edge, reset included.
`define KLFRC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/klfrc_pkg.sv]
// Package of the K-Line frame receiver: status and kind codes, frame constants,
// and the frame store write request type. No dependencies.
package klfrc_pkg;

	typedef logic [3:0] status_t;
	typedef logic [1:0] kind_t;

	localparam kind_t KIND_ARM  = 2'd0;
	localparam kind_t KIND_BYTE = 2'd1;
	localparam kind_t KIND_READ = 2'd2;

	localparam status_t ST_NONE      = 4'd0;
	localparam status_t ST_READY     = 4'd0;
	localparam status_t ST_RECEIVING = 4'd1;
	localparam status_t ST_OK        = 4'd2;
	localparam status_t ST_IDLE      = 4'd3;
	localparam status_t ST_BAD_START = 4'd4;
	localparam status_t ST_LENGTH    = 4'd5;
	localparam status_t ST_TOO_LONG  = 4'd6;
	localparam status_t ST_FOREIGN   = 4'd7;
	localparam status_t ST_SENDER    = 4'd8;
	localparam status_t ST_NEGATIVE  = 4'd9;
	localparam status_t ST_TYPE      = 4'd10;
	localparam status_t ST_CHECKSUM  = 4'd11;

	localparam int BUFFER_DEPTH_DEF = 256;
	localparam int ECHO_MAX_DEF     = 16;
	localparam int ECHO_COUNT_W     = 5;

	localparam logic [7:0] FORMAT_BASE      = 8'h80;
	localparam logic [7:0] ANSWER_WITH_TYPE = 8'h61;
	localparam logic [8:0] LINE_LIMIT       = 9'd132;
	localparam logic [2:0] HDR_SHORT        = 3'd3;
	localparam logic [2:0] HDR_LONG         = 3'd4;
	localparam logic [7:0] POS_FORMAT       = 8'd0;
	localparam logic [7:0] POS_TARGET       = 8'd1;
	localparam logic [7:0] POS_SOURCE       = 8'd2;
	localparam logic [7:0] POS_LENGTH       = 8'd3;

	// APB register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_OWN_ADDR  = 2'd0;
	localparam logic [1:0] REG_ECU_ADDR  = 2'd1;
	localparam logic [1:0] REG_ANSWER    = 2'd2;
	localparam logic [1:0] REG_DATA_TYPE = 2'd3;

	typedef struct packed {
		logic       en;
		logic [7:0] addr;
		logic [7:0] data;
	} store_wr_t;

endpackage

[sv/klfrc_if.sv]
// Valid/ready channel interfaces of the K-Line frame receiver: item and result.
// Depends on klfrc_pkg.
interface klfrc_req_if;
	logic                                  valid;
	logic                                  ready;
	klfrc_pkg::kind_t                      kind;
	logic [7:0]                            data_byte;
	logic [klfrc_pkg::ECHO_COUNT_W-1:0]    echo_count;
	logic [7:0]                            read_index;

	modport source(output valid, kind, data_byte, echo_count, read_index, input ready);
	modport sink(input valid, kind, data_byte, echo_count, read_index, output ready);
endinterface

interface klfrc_rsp_if;
	logic                valid;
	logic                ready;
	klfrc_pkg::status_t  status;
	logic [7:0]          read_data;

	modport source(output valid, status, read_data, input ready);
	modport sink(input valid, status, read_data, output ready);
endinterface

[sv/klfrc_store.sv]
// Frame store of the K-Line frame receiver: one write port, one read port
// with registered read data. Depends on klfrc_pkg.
module klfrc_store #(
	parameter int DEPTH = klfrc_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                  clk,
	input  klfrc_pkg::store_wr_t  wr,
	input  logic                  rd_en,
	input  logic [7:0]            rd_addr,
	output logic [7:0]            rd_data
);
	import klfrc_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/kline_frame_receiver_checker.sv]
// K-Line frame receiver and checker. One item is accepted every clock cycle while results are
// taken. Its result beat passes stage 1, which waits on the registered read of the frame store,
// and then the output register, which holds the beat. A result that is not taken holds the
// output register, and the input stalls once stage 1 is full as well. An arm item clears
// reception and sets the number of echo beats to skip; each received byte is stored and checked
// on the fly (target, sender, answer code, data type, additive checksum) and the result carries
// the receiver status after the item. A read item returns a stored payload byte, zero for an
// address beyond the store. The frame store has no reset; reading a never-written entry gives
// an unspecified byte. Configuration is an APB slave with four 8-bit registers at byte addresses
// 0, 4, 8 and 12.
`include "assert_macros.svh"

module kline_frame_receiver_checker #(
	parameter int BUFFER_DEPTH = klfrc_pkg::BUFFER_DEPTH_DEF,
	parameter int ECHO_MAX     = klfrc_pkg::ECHO_MAX_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	klfrc_req_if.sink    req,
	klfrc_rsp_if.source  rsp,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import klfrc_pkg::*;

	localparam int EW = $clog2(ECHO_MAX + 1);

	// Configuration registers.
	logic [7:0] own_addr_q, ecu_addr_q, answer_q, data_type_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q  <= '0;
			ecu_addr_q  <= '0;
			answer_q    <= '0;
			data_type_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_OWN_ADDR:  own_addr_q  <= pwdata[7:0];
				REG_ECU_ADDR:  ecu_addr_q  <= pwdata[7:0];
				REG_ANSWER:    answer_q    <= pwdata[7:0];
				REG_DATA_TYPE: data_type_q <= pwdata[7:0];
				default:       own_addr_q  <= own_addr_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_OWN_ADDR:  prdata = {24'd0, own_addr_q};
			REG_ECU_ADDR:  prdata = {24'd0, ecu_addr_q};
			REG_ANSWER:    prdata = {24'd0, answer_q};
			REG_DATA_TYPE: prdata = {24'd0, data_type_q};
			default:       prdata = '0;
		endcase
	end

	// Receiver state.
	status_t        rx_state_q, st_n;
	logic [7:0]     byte_pos_q, pos_n;
	logic [2:0]     hdr_len_q, hl_n;
	logic [7:0]     pay_len_q, pl_n;
	logic [EW-1:0]  echo_left_q, echo_n;
	logic [7:0]     sum_q, sum_n;
	status_t        fault_q, cf_n;
	status_t        err;
	logic [8:0]     np, end_pos;
	logic [7:0]     b;
	store_wr_t      st_wr;

	// Pipeline: stage 1 waits on the store read, then the output register.
	logic           acc, adv_s1;
	logic           valid_s1, rd_sel_s1;
	status_t        status_s1;
	logic           out_valid_q;
	status_t        status_q;
	logic [7:0]     read_data_q;
	logic [7:0]     rd_addr, mem_rd;
	logic           rd_en, rd_in_range;

	assign b       = req.data_byte;
	assign adv_s1  = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign acc     = req.valid && req.ready;

	always_comb begin
		st_n    = rx_state_q;
		pos_n   = byte_pos_q;
		hl_n    = hdr_len_q;
		pl_n    = pay_len_q;
		echo_n  = echo_left_q;
		sum_n   = sum_q;
		cf_n    = fault_q;
		err     = ST_NONE;
		np      = {1'b0, byte_pos_q} + 9'd1;
		end_pos = '0;
		st_wr   = '{en: 1'b0, addr: byte_pos_q, data: b};
		unique case (req.kind)
			KIND_ARM: begin
				st_n  = ST_READY;
				pos_n = '0;
				hl_n  = '0;
				pl_n  = '0;
				sum_n = '0;
				cf_n  = ST_NONE;
				if (32'(req.echo_count) > ECHO_MAX) begin
					echo_n = EW'(ECHO_MAX);
				end else begin
					echo_n = EW'(req.echo_count);
				end
			end
			KIND_BYTE: begin
				priority if (rx_state_q > ST_RECEIVING) begin
					st_n = rx_state_q;
				end else if (echo_left_q != '0) begin
					echo_n = echo_left_q - EW'(1);
				end else begin
					st_wr.en = 32'(byte_pos_q) < BUFFER_DEPTH;
					if (byte_pos_q == POS_FORMAT) begin
						if (b < FORMAT_BASE) begin
							err = ST_BAD_START;
						end else begin
							if (b > FORMAT_BASE) begin
								hl_n = HDR_SHORT;
								pl_n = b - FORMAT_BASE;
							end
							st_n = ST_RECEIVING;
						end
					end else if (byte_pos_q == POS_LENGTH && pay_len_q == '0) begin
						hl_n = HDR_LONG;
						pl_n = b;
					end
					// The first field fault sticks until the verdict.
					if (err == ST_NONE && fault_q == ST_NONE) begin
						priority if (byte_pos_q == POS_TARGET && b != own_addr_q) begin
							cf_n = ST_FOREIGN;
						end else if (byte_pos_q == POS_SOURCE && b != ecu_addr_q) begin
							cf_n = ST_SENDER;
						end else if (hl_n != '0 && byte_pos_q == 8'(hl_n)
								&& b != answer_q) begin
							cf_n = ST_NEGATIVE;
						end else if (hl_n != '0 && byte_pos_q == 8'(hl_n) + 8'd1
								&& answer_q == ANSWER_WITH_TYPE && b != data_type_q) begin
							cf_n = ST_TYPE;
						end else begin
							cf_n = fault_q;
						end
					end
					pos_n   = np[7:0];
					end_pos = {1'b0, pl_n} + {6'd0, hl_n} + 9'd1;
					if (pl_n != '0 && np == end_pos) begin
						// Last byte is the checksum; the sum is left as it was.
						if (cf_n != ST_NONE) begin
							st_n = cf_n;
						end else if (b != sum_q) begin
							st_n = ST_CHECKSUM;
						end else begin
							st_n = ST_OK;
						end
					end else begin
						if (pl_n != '0 && np > end_pos) begin
							err = ST_LENGTH;
						end
						if (np > LINE_LIMIT) begin
							err = ST_TOO_LONG;
						end
						if (err != ST_NONE) begin
							st_n = err;
						end else begin
							sum_n = sum_q + b;
						end
					end
				end
			end
			default: begin
				st_n = rx_state_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_state_q  <= ST_IDLE;
			byte_pos_q  <= '0;
			hdr_len_q   <= '0;
			pay_len_q   <= '0;
			echo_left_q <= '0;
			sum_q       <= '0;
			fault_q     <= ST_NONE;
		end else if (acc) begin
			rx_state_q  <= st_n;
			byte_pos_q  <= pos_n;
			hdr_len_q   <= hl_n;
			pay_len_q   <= pl_n;
			echo_left_q <= echo_n;
			sum_q       <= sum_n;
			fault_q     <= cf_n;
		end
	end

	// Payload reads are relative to the header; the address wraps at 256.
	assign rd_addr     = req.read_index + {5'd0, hdr_len_q} - 8'd1;
	assign rd_in_range = 32'(rd_addr) < BUFFER_DEPTH;
	assign rd_en       = acc && req.kind == KIND_READ;

	klfrc_store #(
		.DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk     (clk),
		.wr      ('{en: st_wr.en && acc, addr: st_wr.addr, data: st_wr.data}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= st_n;
			rd_sel_s1 <= rd_en && rd_in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q    <= status_s1;
			read_data_q <= rd_sel_s1 ? mem_rd : 8'd0;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.read_data = read_data_q;

	`KLFRC_ASSERT(a_arm_ready, acc && req.kind == KIND_ARM |=> rx_state_q == ST_READY,
		"arm beat did not leave the receiver ready")
	`KLFRC_ASSERT_ALWAYS(a_echo_bound, 32'(echo_left_q) <= ECHO_MAX,
		"echo skip count above its limit")
	`KLFRC_ASSERT_ALWAYS(a_pos_bound, byte_pos_q <= 8'(LINE_LIMIT) + 8'd1,
		"byte position ran past the line limit")
	`KLFRC_ASSERT(a_stall_blocks, valid_s1 && out_valid_q && !rsp.ready |-> !req.ready,
		"item taken while the pipeline was stalled full")

endmodule

[tb/sv/kline_rx_checker.sv]
`timescale 1ns / 1ps
// Passive checker of the K-Line frame receiver: watches the item, result and APB channels,
// keeps its own copy of the receiver state and compares every result beat against it.
// Depends on klfrc_pkg and the channel interfaces of klfrc_if.sv.
module kline_rx_checker #(
	parameter int STORE_DEPTH = klfrc_pkg::BUFFER_DEPTH_DEF,
	parameter int ECHO_LIMIT  = klfrc_pkg::ECHO_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	klfrc_req_if        req,
	klfrc_rsp_if        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          mismatches,
	output int          pending,
	output int          beats_checked,
	output int          frames_ok,
	output int          frames_rejected
);
	import klfrc_pkg::*;

	typedef struct packed {
		status_t    status;
		logic [7:0] read_data;
	} rx_answer_t;

	logic [7:0] own_addr, ecu_addr, answer_code, data_type;
	logic [7:0] frame_mem [STORE_DEPTH];
	status_t    rx_state, fault;
	logic [7:0] position, payload_len, byte_sum;
	logic [2:0] header_len;
	logic [4:0] echo_left;
	rx_answer_t awaited_answers [$];
	rx_answer_t got, want;
	status_t    was;

	function automatic void note_fault(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%t: %s", $realtime, msg);
	endfunction

	// One line byte: echo skipping, storing, on-the-fly field checks and the verdict.
	function automatic void take_line_byte(logic [7:0] b);
		logic [7:0]  p;
		status_t     err;
		int unsigned np, frame_end;
		p = position;
		err = ST_NONE;
		if (rx_state > ST_RECEIVING)
			return;
		if (echo_left != 5'd0) begin
			echo_left = echo_left - 5'd1;
			return;
		end
		if (int'(p) < STORE_DEPTH)
			frame_mem[p] = b;

		if (p == POS_FORMAT) begin
			if (b < FORMAT_BASE) begin
				err = ST_BAD_START;
			end else begin
				if (b > FORMAT_BASE) begin
					header_len = HDR_SHORT;
					payload_len = b - FORMAT_BASE;
				end
				rx_state = ST_RECEIVING;
			end
		end else if (p == POS_LENGTH && payload_len == 8'd0) begin
			header_len = HDR_LONG;
			payload_len = b;
		end

		// Only the first field fault is kept; it decides the verdict later.
		if (err == ST_NONE && fault == ST_NONE) begin
			if (p == POS_TARGET && b != own_addr)
				fault = ST_FOREIGN;
			else if (p == POS_SOURCE && b != ecu_addr)
				fault = ST_SENDER;
			else if (header_len != 3'd0 && int'(p) == int'(header_len) && b != answer_code)
				fault = ST_NEGATIVE;
			else if (header_len != 3'd0 && int'(p) == int'(header_len) + 1 &&
					answer_code == ANSWER_WITH_TYPE && b != data_type)
				fault = ST_TYPE;
		end

		np = int'(p) + 1;
		position = np[7:0];

		if (payload_len != 8'd0) begin
			frame_end = int'(payload_len) + int'(header_len) + 1;
			if (np == frame_end) begin
				if (fault != ST_NONE)
					rx_state = fault;
				else if (b != byte_sum)
					rx_state = ST_CHECKSUM;
				else
					rx_state = ST_OK;
				return;
			end
			if (np > frame_end)
				err = ST_LENGTH;
		end
		if (np > LINE_LIMIT)
			err = ST_TOO_LONG;

		if (err != ST_NONE)
			rx_state = err;
		else
			byte_sum = byte_sum + b;
	endfunction

	function automatic rx_answer_t apply_item(kind_t k, logic [7:0] d, logic [4:0] e,
			logic [7:0] idx);
		rx_answer_t r;
		logic [7:0] addr;
		r.read_data = 8'h00;
		case (k)
			KIND_ARM: begin
				position = 8'd0;
				header_len = 3'd0;
				payload_len = 8'd0;
				byte_sum = 8'd0;
				fault = ST_NONE;
				echo_left = (int'(e) > ECHO_LIMIT) ? 5'(ECHO_LIMIT) : e;
				rx_state = ST_READY;
			end
			KIND_BYTE: begin
				take_line_byte(d);
			end
			KIND_READ: begin
				addr = idx + {5'd0, header_len} - 8'd1;
				if (int'(addr) < STORE_DEPTH)
					r.read_data = frame_mem[addr];
			end
			default: ;
		endcase
		r.status = rx_state;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr = 8'h00;
			ecu_addr = 8'h00;
			answer_code = 8'h00;
			data_type = 8'h00;
			rx_state = ST_IDLE;
			position = 8'd0;
			header_len = 3'd0;
			payload_len = 8'd0;
			echo_left = 5'd0;
			byte_sum = 8'd0;
			fault = ST_NONE;
			awaited_answers.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_OWN_ADDR:  own_addr = pwdata[7:0];
					REG_ECU_ADDR:  ecu_addr = pwdata[7:0];
					REG_ANSWER:    answer_code = pwdata[7:0];
					REG_DATA_TYPE: data_type = pwdata[7:0];
					default: ;
				endcase
			end

			if (rsp.valid && rsp.ready) begin
				got.status = rsp.status;
				got.read_data = rsp.read_data;
				if (awaited_answers.size() == 0) begin
					note_fault($sformatf("result beat with nothing outstanding: status %0d data %02h",
						got.status, got.read_data));
				end else begin
					want = awaited_answers.pop_front();
					beats_checked++;
					if (got.status !== want.status || got.read_data !== want.read_data)
						note_fault($sformatf(
							"beat %0d: status %0d data %02h, expected status %0d data %02h",
							beats_checked, got.status, got.read_data, want.status,
							want.read_data));
				end
			end

			if (req.valid && req.ready) begin
				was = rx_state;
				awaited_answers.push_back(apply_item(req.kind, req.data_byte, req.echo_count,
					req.read_index));
				if (was <= ST_RECEIVING && rx_state > ST_RECEIVING) begin
					if (rx_state == ST_OK)
						frames_ok++;
					else
						frames_rejected++;
				end
			end
			pending = awaited_answers.size();
		end
	end

endmodule

[tb/sv/tb_kline_frame_receiver_checker.sv]
`timescale 1ns / 1ps
// Top of the K-Line frame receiver testbench: clock, reset, APB register writes and the
// item stimulus with random idling. Depends on klfrc_pkg, klfrc_if.sv, the receiver RTL
// and kline_rx_checker, which judges every result beat.
module tb_kline_frame_receiver_checker;
	import klfrc_pkg::*;

	localparam int STIM_ITEMS  = 400;
	localparam int WRITTEN_TOP = 132;	// highest store address any frame can reach

	typedef enum int {
		FLAW_NONE,
		FLAW_TARGET,
		FLAW_SOURCE,
		FLAW_ANSWER,
		FLAW_TYPE,
		FLAW_SUM
	} frame_flaw_t;

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        steady;	// no idling on either side while set
	logic [7:0]  reg_val [4];
	int          mismatches, pending, beats_checked, frames_ok, frames_rejected;
	int          items_sent, settings;

	klfrc_req_if req_ch();
	klfrc_rsp_if rsp_ch();

	kline_frame_receiver_checker dut (
		.clk, .arst_n, .req(req_ch), .rsp(rsp_ch),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	kline_rx_checker watch (
		.clk, .arst_n, .req(req_ch), .rsp(rsp_ch),
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.mismatches, .pending, .beats_checked, .frames_ok, .frames_rejected
	);

	always #4 clk = ~clk;

	always @(posedge clk)
		rsp_ch.ready <= steady || ($urandom_range(99) >= 9);

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_item(kind_t k, logic [7:0] d, logic [4:0] e, logic [7:0] idx);
		if (!steady && $urandom_range(99) < 9) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.data_byte <= d;
		req_ch.echo_count <= e;
		req_ch.read_index <= idx;
		// ready only changes at a rising edge, so the falling edge sees its final value
		do @(negedge clk); while (!req_ch.ready);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic arm_rx(logic [4:0] e);
		send_item(KIND_ARM, 8'($urandom_range(255)), e, 8'($urandom_range(255)));
	endtask

	task automatic line_byte(logic [7:0] b);
		send_item(KIND_BYTE, b, 5'($urandom_range(16)), 8'($urandom_range(255)));
	endtask

	task automatic read_byte(logic [7:0] addr, logic [2:0] hl);
		logic [7:0] idx;
		idx = addr - {5'd0, hl} + 8'd1;
		send_item(KIND_READ, 8'($urandom_range(255)), 5'($urandom_range(16)), idx);
	endtask

	// Indexes 1 to 129 hit written entries whatever the header length is.
	task automatic read_any();
		send_item(KIND_READ, 8'($urandom_range(255)), 5'($urandom_range(16)),
			8'($urandom_range(129, 1)));
	endtask

	task automatic reg_write(logic [1:0] idx, logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'h0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		reg_val[idx] = v;
	endtask

	task automatic set_registers(logic [7:0] own, logic [7:0] ecu, logic [7:0] ans,
			logic [7:0] typ);
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
		reg_write(REG_OWN_ADDR, own);
		reg_write(REG_ECU_ADDR, ecu);
		reg_write(REG_ANSWER, ans);
		reg_write(REG_DATA_TYPE, typ);
		psel <= 1'b0;
		penable <= 1'b0;
		settings++;
	endtask

	// Arms, sends the echo beats, then a frame built from the current registers. A cut of
	// zero or more stops after that many frame bytes.
	task automatic send_frame(int echo, bit long_form, int len, frame_flaw_t flaw, int cut,
			output logic [2:0] hl);
		logic [7:0] frame_q [$];
		logic [7:0] sum, tweak;
		int         body, n;
		hl = long_form ? HDR_LONG : HDR_SHORT;
		tweak = 8'($urandom_range(255, 1));
		// A zero length in byte 3 never ends, so feed enough bytes to reach the line limit.
		body = (long_form && len == 0) ? 129 : len;
		arm_rx(5'(echo));
		repeat (echo) line_byte(8'($urandom_range(255)));
		frame_q.push_back(long_form ? FORMAT_BASE : FORMAT_BASE + 8'(len));
		frame_q.push_back(reg_val[REG_OWN_ADDR]);
		frame_q.push_back(reg_val[REG_ECU_ADDR]);
		if (long_form)
			frame_q.push_back(8'(len));
		for (int i = 0; i < body; i++) begin
			if (i == 0)
				frame_q.push_back(reg_val[REG_ANSWER]);
			else if (i == 1)
				frame_q.push_back(reg_val[REG_DATA_TYPE]);
			else
				frame_q.push_back(8'($urandom_range(255)));
		end
		case (flaw)
			FLAW_TARGET: frame_q[1] = frame_q[1] ^ tweak;
			FLAW_SOURCE: frame_q[2] = frame_q[2] ^ tweak;
			FLAW_ANSWER: if (body > 0) frame_q[hl] = frame_q[hl] ^ tweak;
			FLAW_TYPE:   if (body > 1) frame_q[hl + 1] = frame_q[hl + 1] ^ tweak;
			default: ;
		endcase
		sum = 8'h00;
		foreach (frame_q[i])
			sum = sum + frame_q[i];
		frame_q.push_back(flaw == FLAW_SUM ? sum ^ tweak : sum);
		n = (cut >= 0 && cut < frame_q.size()) ? cut : frame_q.size();
		for (int i = 0; i < n; i++)
			line_byte(frame_q[i]);
	endtask

	initial begin
		logic [2:0] hl;
		int         seq_no, roll, len, echo;
		bit         long_form;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 4'h0;
		pwdata = 32'h0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_ARM;
		req_ch.data_byte = 8'h00;
		req_ch.echo_count = 5'd0;
		req_ch.read_index = 8'h00;
		rsp_ch.ready = 1'b0;
		steady = 1'b0;
		foreach (reg_val[i])
			reg_val[i] = 8'h00;
		items_sent = 0;
		settings = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A byte before any arm is ignored by the idle receiver.
		line_byte(8'h81);
		// Zero length in byte 3 runs to the line limit and fills every reachable store entry.
		arm_rx(5'd0);
		line_byte(FORMAT_BASE);
		line_byte(8'h00);
		line_byte(8'hFF);
		line_byte(8'h00);
		for (int i = 4; i <= WRITTEN_TOP; i++)
			line_byte(8'($urandom_range(255)));
		line_byte(8'hFF);

		set_registers(8'hF1, 8'h10, ANSWER_WITH_TYPE, 8'h07);
		send_frame(1, 1'b1, 2, FLAW_NONE, -1, hl);
		read_byte(8'd0, hl);
		read_byte(8'(WRITTEN_TOP), hl);
		send_item(KIND_READ, 8'h00, 5'd0, 8'hFF);
		send_item(KIND_READ, 8'hFF, 5'd16, 8'h00);
		line_byte(8'h55);
		arm_rx(5'd0);
		line_byte(8'h7F);
		send_frame(0, 1'b0, 1, FLAW_NONE, -1, hl);
		arm_rx(5'd16);

		seq_no = 0;
		while (items_sent < STIM_ITEMS) begin
			if (seq_no % 3 == 0) begin
				case ((seq_no / 3) % 4)
					0: set_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
					1: set_registers(8'h00, 8'h00, 8'h00, 8'h00);
					2: set_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
						ANSWER_WITH_TYPE, 8'($urandom_range(255)));
					default: set_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)));
				endcase
			end
			steady = (seq_no >= 4 && seq_no < 8);
			long_form = 1'($urandom_range(1));
			roll = $urandom_range(99);
			len = (roll < 85) ? $urandom_range(8, 1) :
				(roll < 95) ? $urandom_range(40, 9) : $urandom_range(long_form ? 128 : 127, 41);
			echo = ($urandom_range(99) < 60) ? 0 : $urandom_range(16);
			roll = $urandom_range(99);
			if (roll < 60) begin
				send_frame(echo, long_form, len, FLAW_NONE, -1, hl);
				if ($urandom_range(3) == 0)
					repeat ($urandom_range(2, 1)) line_byte(8'($urandom_range(255)));
				repeat ($urandom_range(3)) read_byte(8'($urandom_range(WRITTEN_TOP)), hl);
			end else if (roll < 85) begin
				case ($urandom_range(4))
					0, 1: begin
						send_frame(echo, long_form, $urandom_range(8, 1),
							frame_flaw_t'($urandom_range(FLAW_SUM, FLAW_TARGET)), -1, hl);
						read_byte(8'($urandom_range(WRITTEN_TOP)), hl);
					end
					2: begin
						send_frame(echo, long_form, len, FLAW_NONE, $urandom_range(len + 2, 1),
							hl);
						read_any();
					end
					3: begin
						arm_rx(5'($urandom_range(3)));
						repeat (int'(watch.echo_left)) ;
						line_byte(8'($urandom_range(127)));
						repeat ($urandom_range(2)) line_byte(8'($urandom_range(255)));
						read_any();
					end
					default: begin
						send_frame(0, 1'b1, ($urandom_range(3) == 0) ? 0 : $urandom_range(255, 129),
							FLAW_NONE, -1, hl);
						read_any();
					end
				endcase
			end else begin
				repeat ($urandom_range(6, 1)) begin
					case ($urandom_range(2))
						0: arm_rx(5'($urandom_range(16)));
						1: line_byte(8'($urandom_range(255)));
						default: read_any();
					endcase
				end
			end
			seq_no++;
		end

		steady = 1'b0;
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		$display("Run sent %0d items over %0d register settings and checked %0d beats.",
			items_sent, settings, beats_checked);
		$display("Frames judged: %0d accepted, %0d rejected with an error verdict.",
			frames_ok, frames_rejected);
		if (mismatches == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/klfrc_pkg.sv
sv/klfrc_if.sv
sv/klfrc_store.sv
sv/kline_frame_receiver_checker.sv
tb/sv/kline_rx_checker.sv
tb/sv/tb_kline_frame_receiver_checker.sv
